FILE: rtl/lzss_stream_decompressor_assert.svh
// assertion macros for the lzss decompressor
`ifndef LZSS_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LZSS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LZSS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZSS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define LZSS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

    localparam int WINDOW_BITS_DEF = 12;
    localparam int MAX_LENGTH_BITS = 5;
    localparam int REF_ACC_BITS    = 16;
    localparam int LEN_CALC_BITS   = REF_ACC_BITS + 1;

    localparam logic [2:0]  FLAG_BYTES_RST  = 3'd1;
    localparam logic [3:0]  OFFSET_BITS_RST = 4'd12;
    localparam logic [2:0]  LENGTH_BITS_RST = 3'd4;
    localparam logic [31:0] OUT_LIMIT_RST   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CFG_FLAG_BYTES  = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_LENGTH_BITS = 2'd2,
        CFG_OUT_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_BAD_CONFIG = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_FLAGS   = 2'd0,
        PH_TOKENS  = 2'd1,
        PH_STOPPED = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_COPY_RD,
        S_COPY_WR,
        S_FINAL
    } fsm_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_final;
        logic        last_of_run;
        status_t     status;
        logic [31:0] total_count;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/lzss_window_ram.sv
`default_nettype none

module lzss_window_ram #(
    parameter int ADDR_BITS = 12
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [7:0]           wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [7:0]           rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/lzss_stream_decompressor.sv
// path: an input byte is registered and decoded in S_DECODE; a literal is then
//   registered for output, the first byte of a copy after S_COPY_RD and S_COPY_WR
// a new byte is taken only in S_IDLE, after the last flag, reference or literal
//   byte and any copy it starts are done; each copied byte is a window ram read then a write
//   of the same ram; the end-of-stream result is offered from S_FINAL, then the
//   window is swept to zero with no input taken; the same sweep runs after reset
// reset: asynchronous active low, configuration registers to defaults, stream state cleared
`default_nettype none

`include "lzss_stream_decompressor_assert.svh"

module lzss_stream_decompressor #(
    parameter int WINDOW_BITS = lzss_pkg::WINDOW_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lzss_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lzss_pkg::out_item_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lzss_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]           cfg_data
);

    import lzss_pkg::*;

    localparam int AW = WINDOW_BITS;
    localparam int SW = WINDOW_BITS + 1;

    // configuration
    logic [2:0]  flag_bytes_reg;
    logic [3:0]  offset_bits_reg;
    logic [2:0]  length_bits_reg;
    logic [31:0] out_limit_reg;

    // control and stream state
    fsm_t        state_reg, state_next;
    phase_t      phase_reg, phase_next;
    status_t     status_reg, status_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0] flag_shift_reg, flag_shift_next;
    logic [5:0]  flag_left_reg, flag_left_next;
    logic [1:0]  flag_seen_reg, flag_seen_next;
    logic [REF_ACC_BITS-1:0] ref_acc_reg, ref_acc_next;
    logic [1:0]  ref_seen_reg, ref_seen_next;
    logic [31:0] out_count_reg, out_count_next;
    logic [SW-1:0] copy_left_reg, copy_left_next;

    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    // window ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // decode helpers
    logic [SW-1:0] win_size;
    logic [AW-1:0] mask;
    logic          cfg_ok;
    logic [4:0]    field_sum;
    logic [1:0]    ref_len;
    logic          out_free;
    logic          below_limit;
    logic [31:0]   count_inc;
    logic [31:0]   flag_fill;
    logic [2:0]    flag_seen_inc;
    logic [REF_ACC_BITS-1:0] acc_fill;
    logic [1:0]    ref_seen_inc;
    logic [AW-1:0] ref_off;
    logic [LEN_CALC_BITS-1:0] ref_copy_len;
    logic          too_long;
    logic          more;
    logic          finish;
    logic          emit;
    out_item_t     emit_item;

    assign win_size  = SW'(1) << offset_bits_reg;
    assign mask      = AW'(win_size - SW'(1));
    assign field_sum = 5'(offset_bits_reg) + 5'(length_bits_reg);
    assign ref_len   = field_sum[4:3];
    assign cfg_ok    = (flag_bytes_reg >= 3'd1) && (flag_bytes_reg <= 3'd4)
                    && (offset_bits_reg >= 4'd3)
                    && (5'(offset_bits_reg) <= 5'(WINDOW_BITS))
                    && (length_bits_reg <= 3'(MAX_LENGTH_BITS))
                    && (field_sum[2:0] == 3'd0);

    assign out_free    = !out_valid_reg || out_ready;
    assign below_limit = out_count_reg < out_limit_reg;
    assign count_inc   = out_count_reg + 32'd1;

    assign flag_fill     = flag_shift_reg
                         | (32'(in_item_reg.in_byte) << {flag_seen_reg, 3'b000});
    assign flag_seen_inc = {1'b0, flag_seen_reg} + 3'd1;

    assign acc_fill     = ref_acc_reg
                        | (REF_ACC_BITS'(in_item_reg.in_byte) << (ref_seen_reg[0] ? 4'd8 : 4'd0));
    assign ref_seen_inc = ref_seen_reg + 2'd1;
    assign ref_off      = AW'(acc_fill) & mask;
    assign ref_copy_len = LEN_CALC_BITS'(acc_fill >> offset_bits_reg) + LEN_CALC_BITS'(3);
    assign too_long     = ref_copy_len > LEN_CALC_BITS'(win_size);

    assign more = (copy_left_reg != SW'(1)) && (count_inc < out_limit_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        status_next     = status_reg;
        wp_next         = wp_reg;
        rd_next         = rd_reg;
        clr_cnt_next    = clr_cnt_reg;
        flag_shift_next = flag_shift_reg;
        flag_left_next  = flag_left_reg;
        flag_seen_next  = flag_seen_reg;
        ref_acc_next    = ref_acc_reg;
        ref_seen_next   = ref_seen_reg;
        out_count_next  = out_count_reg;
        copy_left_next  = copy_left_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg & mask;
        ram_wdata       = in_item_reg.in_byte;
        ram_re          = 1'b0;
        ram_raddr       = rd_reg & mask;
        finish          = 1'b1;
        emit            = 1'b0;
        emit_item       = '{data_byte: 8'd0, is_final: 1'b0, last_of_run: 1'b0,
                            status: ST_OK, total_count: 32'd0};

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (phase_reg != PH_FLAGS && phase_reg != PH_TOKENS)
                begin
                    // stopped stream swallows bytes
                end
                else if (!cfg_ok)
                begin
                    phase_next  = PH_STOPPED;
                    status_next = ST_BAD_CONFIG;
                end
                else if (phase_reg == PH_FLAGS)
                begin
                    flag_shift_next = flag_fill;
                    if (flag_seen_inc >= flag_bytes_reg)
                    begin
                        flag_seen_next = 2'd0;
                        flag_left_next = {flag_bytes_reg, 3'b000};
                        phase_next     = PH_TOKENS;
                    end
                    else
                    begin
                        flag_seen_next = flag_seen_inc[1:0];
                    end
                end
                else if (!flag_shift_reg[0])
                begin
                    if (!below_limit)
                    begin
                        phase_next  = PH_STOPPED;
                        status_next = ST_OK;
                    end
                    else if (!out_free)
                    begin
                        finish = 1'b0;
                    end
                    else
                    begin
                        emit                  = 1'b1;
                        emit_item.data_byte   = in_item_reg.in_byte;
                        emit_item.last_of_run = !in_item_reg.last_byte;
                        ram_we                = 1'b1;
                        wp_next               = (wp_reg + AW'(1)) & mask;
                        out_count_next        = count_inc;
                        flag_shift_next       = flag_shift_reg >> 1;
                        flag_left_next        = flag_left_reg - 6'd1;
                        if (flag_left_next == 6'd0)
                        begin
                            phase_next = PH_FLAGS;
                        end
                    end
                end
                else
                begin
                    ref_acc_next  = acc_fill;
                    ref_seen_next = ref_seen_inc;
                    if (ref_seen_inc >= ref_len)
                    begin
                        ref_acc_next  = '0;
                        ref_seen_next = 2'd0;
                        if (too_long)
                        begin
                            phase_next  = PH_STOPPED;
                            status_next = ST_BAD_LENGTH;
                        end
                        else if (!below_limit)
                        begin
                            phase_next  = PH_STOPPED;
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            rd_next        = (wp_reg - ref_off - AW'(1)) & mask;
                            copy_left_next = ref_copy_len[SW-1:0];
                            finish         = 1'b0;
                            state_next     = S_COPY_RD;
                        end
                    end
                end

                if (finish)
                begin
                    state_next = in_item_reg.last_byte ? S_FINAL : S_IDLE;
                end
            end

            S_COPY_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_COPY_WR;
            end

            S_COPY_WR:
            begin
                // the byte is written back before the next read, so overlapping copies see it
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_item.data_byte   = ram_rdata;
                    emit_item.last_of_run = !more && !in_item_reg.last_byte;
                    ram_we                = 1'b1;
                    ram_wdata             = ram_rdata;
                    wp_next               = (wp_reg + AW'(1)) & mask;
                    rd_next               = (rd_reg + AW'(1)) & mask;
                    out_count_next        = count_inc;
                    copy_left_next        = copy_left_reg - SW'(1);
                    if (more)
                    begin
                        state_next = S_COPY_RD;
                    end
                    else
                    begin
                        if (copy_left_reg == SW'(1))
                        begin
                            flag_shift_next = flag_shift_reg >> 1;
                            flag_left_next  = flag_left_reg - 6'd1;
                            if (flag_left_next == 6'd0)
                            begin
                                phase_next = PH_FLAGS;
                            end
                        end
                        else
                        begin
                            phase_next  = PH_STOPPED;
                            status_next = ST_OVERFLOW;
                        end
                        state_next = in_item_reg.last_byte ? S_FINAL : S_IDLE;
                    end
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_item.is_final    = 1'b1;
                    emit_item.last_of_run = 1'b1;
                    emit_item.status      = status_reg;
                    emit_item.total_count = out_count_reg;
                    phase_next            = PH_FLAGS;
                    status_next           = ST_OK;
                    wp_next               = '0;
                    flag_shift_next       = '0;
                    flag_left_next        = '0;
                    flag_seen_next        = '0;
                    ref_acc_next          = '0;
                    ref_seen_next         = '0;
                    out_count_next        = '0;
                    state_next            = S_CLEAR;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            phase_reg      <= PH_FLAGS;
            status_reg     <= ST_OK;
            wp_reg         <= '0;
            clr_cnt_reg    <= '0;
            flag_shift_reg <= '0;
            flag_left_reg  <= '0;
            flag_seen_reg  <= '0;
            ref_acc_reg    <= '0;
            ref_seen_reg   <= '0;
            out_count_reg  <= '0;
            copy_left_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            status_reg     <= status_next;
            wp_reg         <= wp_next;
            clr_cnt_reg    <= clr_cnt_next;
            flag_shift_reg <= flag_shift_next;
            flag_left_reg  <= flag_left_next;
            flag_seen_reg  <= flag_seen_next;
            ref_acc_reg    <= ref_acc_next;
            ref_seen_reg   <= ref_seen_next;
            out_count_reg  <= out_count_next;
            copy_left_reg  <= copy_left_next;
            out_valid_reg  <= emit || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bytes_reg  <= FLAG_BYTES_RST;
            offset_bits_reg <= OFFSET_BITS_RST;
            length_bits_reg <= LENGTH_BITS_RST;
            out_limit_reg   <= OUT_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FLAG_BYTES:  flag_bytes_reg  <= cfg_data[2:0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[3:0];
                CFG_LENGTH_BITS: length_bits_reg <= cfg_data[2:0];
                CFG_OUT_LIMIT:   out_limit_reg   <= cfg_data;
                default:         out_limit_reg   <= out_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        rd_reg <= rd_next;
        if (emit)
        begin
            out_item_reg <= emit_item;
        end
    end

    lzss_window_ram #(
        .ADDR_BITS (WINDOW_BITS)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `LZSS_ASSERT_IMP(a_emit_slot_free, clk, rst_n, emit, !out_valid_reg || out_ready, "result loaded over a pending transfer")
    `LZSS_ASSERT_IMP(a_final_ends_run, clk, rst_n, out_valid && out_data.is_final, out_data.last_of_run, "end-of-stream result not marked last of run")
    `LZSS_ASSERT_IMP(a_copy_nonempty, clk, rst_n, state_reg == S_COPY_RD || state_reg == S_COPY_WR, copy_left_reg != '0, "copy running with no bytes left")
    `LZSS_ASSERT_NXT(a_copy_advance, clk, rst_n, state_reg == S_COPY_WR && out_free, wp_reg == (($past(wp_reg) + AW'(1)) & $past(mask)), "write pointer did not advance on a copied byte")

endmodule

`default_nettype wire
